### rtl/core/skc_pkg.sv
`timescale 1ns / 1ps
package skc_pkg;

    localparam int BLK_W  = 64;
    localparam int KEY_W  = 32;
    localparam int RIDX_W = 6;
    localparam int MAX_ROUNDS = 36;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_FILL,
        ST_PRIME,
        ST_DEC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              load;
        logic              enc_round;
        logic              dec_round;
        logic              sched_step;
        logic              out_load;
        logic [RIDX_W-1:0] rc_idx;
    } t_cmd;

    localparam logic [3:0] SBOX [16] = '{
        4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
        4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h3, 4'h4, 4'h6, 4'h8, 4'hc, 4'ha, 4'h1, 4'he,
        4'h9, 4'h2, 4'h5, 4'h7, 4'h0, 4'hb, 4'hd, 4'hf
    };
    localparam logic [3:0] SHIFT_MAP [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
        4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
    };
    localparam logic [3:0] SHIFT_MAP_INV [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4,
        4'd10, 4'd11, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14
    };
    localparam logic [3:0] TK_MAP [16] = '{
        4'h9, 4'hf, 4'h8, 4'hd, 4'ha, 4'he, 4'hc, 4'hb,
        4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7
    };
    localparam logic [5:0] RCON [MAX_ROUNDS] = '{
        6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F, 6'h1E, 6'h3C,
        6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
        6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D
    };
    localparam logic [3:0] CONST_ROW2 = 4'h2;

    function automatic logic [5:0] round_const(input logic [RIDX_W-1:0] idx);
        logic [5:0] rc;
        rc = 6'h00;
        for (int i = 0; i < MAX_ROUNDS; i++) begin
            if (idx == RIDX_W'(i)) begin
                rc = RCON[i];
            end
        end
        return rc;
    endfunction

    function automatic logic [63:0] enc_round(input logic [63:0] b, input logic [31:0] k,
                                              input logic [5:0] rc);
        logic [3:0]  c [16];
        logic [3:0]  t [16];
        logic [3:0]  x;
        logic [63:0] r;
        for (int i = 0; i < 16; i++) begin
            c[i] = SBOX[b[63-4*i -: 4]];
        end
        c[0] = c[0] ^ rc[3:0];
        c[4] = c[4] ^ {2'b00, rc[5:4]};
        c[8] = c[8] ^ CONST_ROW2;
        for (int i = 0; i < 8; i++) begin
            c[i] = c[i] ^ k[31-4*i -: 4];
        end
        t = c;
        for (int i = 0; i < 16; i++) begin
            c[i] = t[SHIFT_MAP[i]];
        end
        for (int j = 0; j < 4; j++) begin
            c[j+4]  = c[j+4] ^ c[j+8];
            c[j+8]  = c[j+8] ^ c[j];
            c[j+12] = c[j+12] ^ c[j+8];
            x       = c[j+12];
            c[j+12] = c[j+8];
            c[j+8]  = c[j+4];
            c[j+4]  = c[j];
            c[j]    = x;
        end
        for (int i = 0; i < 16; i++) begin
            r[63-4*i -: 4] = c[i];
        end
        return r;
    endfunction

    function automatic logic [63:0] dec_round(input logic [63:0] b, input logic [31:0] k,
                                              input logic [5:0] rc);
        logic [3:0]  c [16];
        logic [3:0]  t [16];
        logic [3:0]  x;
        logic [63:0] r;
        for (int i = 0; i < 16; i++) begin
            c[i] = b[63-4*i -: 4];
        end
        for (int j = 0; j < 4; j++) begin
            x       = c[j+12];
            c[j+12] = c[j];
            c[j]    = c[j+4];
            c[j+4]  = c[j+8];
            c[j+8]  = x;
            c[j+12] = c[j+12] ^ c[j+8];
            c[j+8]  = c[j+8] ^ c[j];
            c[j+4]  = c[j+4] ^ c[j+8];
        end
        t = c;
        for (int i = 0; i < 16; i++) begin
            c[i] = t[SHIFT_MAP_INV[i]];
        end
        c[0] = c[0] ^ rc[3:0];
        c[4] = c[4] ^ {2'b00, rc[5:4]};
        c[8] = c[8] ^ CONST_ROW2;
        for (int i = 0; i < 8; i++) begin
            c[i] = c[i] ^ k[31-4*i -: 4];
        end
        for (int i = 0; i < 16; i++) begin
            r[63-4*i -: 4] = SBOX_INV[c[i]];
        end
        return r;
    endfunction

    function automatic logic [63:0] tk_permute(input logic [63:0] w, input logic lfsr);
        logic [3:0]  c [16];
        logic [3:0]  x;
        logic [63:0] r;
        for (int i = 0; i < 16; i++) begin
            c[i] = w[63-4*TK_MAP[i] -: 4];
        end
        if (lfsr) begin
            for (int i = 0; i < 8; i++) begin
                x    = c[i];
                c[i] = {x[2:0], x[3] ^ x[2]};
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[63-4*i -: 4] = c[i];
        end
        return r;
    endfunction

endpackage

### rtl/core/skc_if.sv
`timescale 1ns / 1ps
interface skc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] block_in;

    modport source (output valid, output action, output block_in, input ready);
    modport sink (input valid, input action, input block_in, output ready);
endinterface

interface skc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink (input valid, input block_out, output ready);
endinterface

### rtl/core/skc_ram.sv
`timescale 1ns / 1ps
module skc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/skc_ctrl.sv
`timescale 1ns / 1ps
module skc_ctrl
    import skc_pkg::*;
#(
    parameter int ROUND_COUNT = 36
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    input  logic                                         i_in_action,
    output logic                                         o_in_ready,
    input  logic                                         i_out_ready,
    output logic                                         o_out_valid,
    output t_cmd                                         o_cmd,
    output logic                                         o_ram_we,
    output logic [(ROUND_COUNT > 1 ? $clog2(ROUND_COUNT) : 1)-1:0] o_ram_addr
);

    localparam int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [AW-1:0] LAST = AW'(ROUND_COUNT - 1);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] n_cnt;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_action ? ST_FILL : ST_ENC;
                end
            end
            ST_ENC: begin
                if (r_cnt == LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FILL: begin
                if (r_cnt == LAST) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_DEC;
            end
            ST_DEC: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_state == ST_IDLE) begin
            n_cnt = '0;
        end else if ((r_state == ST_ENC || r_state == ST_FILL) && r_cnt != LAST) begin
            n_cnt = r_cnt + 1'b1;
        end else if (r_state == ST_DEC && r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_ram_we         = 1'b0;
        o_ram_addr       = r_cnt;
        o_in_ready       = 1'b0;
        n_out_valid      = r_out_valid && !i_out_ready;
        o_cmd.rc_idx     = RIDX_W'(r_cnt);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ENC: begin
                o_cmd.enc_round  = 1'b1;
                o_cmd.sched_step = 1'b1;
                o_ram_we         = 1'b1;
            end
            ST_FILL: begin
                o_cmd.sched_step = 1'b1;
                o_ram_we         = 1'b1;
            end
            ST_PRIME: begin
                o_ram_addr = r_cnt;
            end
            ST_DEC: begin
                o_cmd.dec_round = 1'b1;
                o_ram_addr      = (r_cnt == '0) ? '0 : r_cnt - 1'b1;
            end
            ST_FIN: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/skc_dpath.sv
`timescale 1ns / 1ps
module skc_dpath
    import skc_pkg::*;
(
    input  logic             i_clk,
    input  t_cmd             i_cmd,
    input  logic [BLK_W-1:0] i_block,
    input  logic [BLK_W-1:0] i_tk1,
    input  logic [BLK_W-1:0] i_tk2,
    input  logic [KEY_W-1:0] i_ram_rdata,
    output logic [KEY_W-1:0] o_key,
    output logic [BLK_W-1:0] o_block
);

    logic [BLK_W-1:0] r_block;
    logic [BLK_W-1:0] r_s1;
    logic [BLK_W-1:0] r_s2;
    logic [BLK_W-1:0] r_out;
    logic [BLK_W-1:0] sched_xor;
    logic [5:0]       rc;

    assign sched_xor = r_s1 ^ r_s2;
    assign o_key     = sched_xor[BLK_W-1 -: KEY_W];
    assign rc        = round_const(i_cmd.rc_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_block <= i_block;
            r_s1    <= i_tk1;
            r_s2    <= i_tk2;
        end else begin
            if (i_cmd.enc_round) begin
                r_block <= enc_round(r_block, o_key, rc);
            end else if (i_cmd.dec_round) begin
                r_block <= dec_round(r_block, i_ram_rdata, rc);
            end
            if (i_cmd.sched_step) begin
                r_s1 <= tk_permute(r_s1, 1'b0);
                r_s2 <= tk_permute(r_s2, 1'b1);
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_block;
        end
    end

    assign o_block = r_out;

endmodule

### rtl/core/skinny64_tweakable_block_cipher.sv
`timescale 1ns / 1ps
// Encryption runs one round per cycle from acceptance to result,
// with the subkey memory written alongside. Decryption fills the subkey memory first,
// then reads it back in reverse order through its one read port.
// A new block is accepted only once the controller is idle again, after the last result is loaded for output.
// Synchronous active-low reset clears the controller, the output valid and both tweakey words.
module skinny64_tweakable_block_cipher
    import skc_pkg::*;
#(
    parameter int ROUND_COUNT = 36
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skc_in_if.sink      i_blk,
    skc_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // The round count is held to the range that the constant table covers.
    localparam int ROUNDS_USED = (ROUND_COUNT < 1) ? 1 :
                                 ((ROUND_COUNT > MAX_ROUNDS) ? MAX_ROUNDS : ROUND_COUNT);
    localparam int AW = (ROUNDS_USED > 1) ? $clog2(ROUNDS_USED) : 1;

    logic [BLK_W-1:0] r_tk1;
    logic [BLK_W-1:0] r_tk2;
    t_cmd             cmd;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [KEY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] key;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? r_tk2 : r_tk1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk1 <= '0;
            r_tk2 <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[3]) begin
                r_tk2 <= pwdata;
            end else begin
                r_tk1 <= pwdata;
            end
        end
    end

    skc_ctrl #(
        .ROUND_COUNT(ROUNDS_USED)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_blk.valid),
        .i_in_action (i_blk.action),
        .o_in_ready  (i_blk.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr)
    );

    skc_ram #(
        .WIDTH(KEY_W),
        .DEPTH(ROUNDS_USED)
    ) u_subkey_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (key),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    skc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_block     (i_blk.block_in),
        .i_tk1       (r_tk1),
        .i_tk2       (r_tk2),
        .i_ram_rdata (ram_rdata),
        .o_key       (key),
        .o_block     (o_res.block_out)
    );

endmodule

### bench/tb_skinny64_tweakable_block_cipher.sv
`timescale 1ns / 1ps
module tb_skinny64_tweakable_block_cipher;
    import skc_pkg::*;

    localparam int ROUNDS = 36;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 210;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam bit [3:0] REG_TWEAKEY_ONE = 4'h0;
    localparam bit [3:0] REG_TWEAKEY_TWO = 4'h8;

    typedef enum bit {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } cipher_op_e;

    localparam bit [3:0] SUB_CELL [16] = '{
        4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
        4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
    };
    localparam bit [3:0] SUB_CELL_INV [16] = '{
        4'h3, 4'h4, 4'h6, 4'h8, 4'hc, 4'ha, 4'h1, 4'he,
        4'h9, 4'h2, 4'h5, 4'h7, 4'h0, 4'hb, 4'hd, 4'hf
    };
    localparam int ROW_SHIFT [16] = '{0, 1, 2, 3, 7, 4, 5, 6, 10, 11, 8, 9, 13, 14, 15, 12};
    localparam int ROW_SHIFT_INV [16] = '{0, 1, 2, 3, 5, 6, 7, 4, 10, 11, 8, 9, 15, 12, 13, 14};
    localparam int TWEAK_PERM [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    skc_in_if  blk_if ();
    skc_out_if res_if ();

    skinny64_tweakable_block_cipher #(
        .ROUND_COUNT(ROUNDS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit [63:0] tk1_setting;
    bit [63:0] tk2_setting;
    bit [63:0] expected_blocks [$];
    bit        sender_gaps_on;
    bit        receiver_stalls_on;
    int        mismatches = 0;
    int        cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_skinny64_tweakable_block_cipher: done, errors");
            $finish;
        end
    end

    // The whole tweakey schedule is rebuilt for every block, as the hardware does.
    function automatic bit [63:0] skinny_transform(input cipher_op_e op, input bit [63:0] blk,
                                                   input bit [63:0] tk1, input bit [63:0] tk2);
        bit [63:0] tweak_mask [ROUNDS];
        bit [3:0]  c [16];
        bit [3:0]  t [16];
        bit [3:0]  a [16];
        bit [3:0]  b [16];
        bit [3:0]  r1;
        bit [3:0]  r2;
        bit [3:0]  r3;
        bit [3:0]  top;
        bit [5:0]  rc;
        bit [63:0] result;
        int        k;
        rc = 6'h00;
        for (int r = 0; r < ROUNDS; r++) begin
            rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
            tweak_mask[r] = {tk1[63:32] ^ tk2[63:32], 32'h0}
                            ^ (64'(rc[3:0]) << 60) ^ (64'(rc[5:4]) << 44) ^ (64'h2 << 28);
            for (int n = 0; n < 16; n++) begin
                a[n] = tk1[63-4*TWEAK_PERM[n] -: 4];
                b[n] = tk2[63-4*TWEAK_PERM[n] -: 4];
            end
            for (int n = 0; n < 8; n++) begin
                b[n] = {b[n][2:0], b[n][3] ^ b[n][2]};
            end
            for (int n = 0; n < 16; n++) begin
                tk1[63-4*n -: 4] = a[n];
                tk2[63-4*n -: 4] = b[n];
            end
        end
        for (int n = 0; n < 16; n++) begin
            c[n] = blk[63-4*n -: 4];
        end
        for (int r = 0; r < ROUNDS; r++) begin
            if (op == OP_ENCRYPT) begin
                for (int n = 0; n < 16; n++) begin
                    c[n] = SUB_CELL[c[n]] ^ tweak_mask[r][63-4*n -: 4];
                end
                t = c;
                for (int n = 0; n < 16; n++) begin
                    c[n] = t[ROW_SHIFT[n]];
                end
                for (int j = 0; j < 4; j++) begin
                    r1 = c[j+4] ^ c[j+8];
                    r2 = c[j+8] ^ c[j];
                    r3 = c[j+12] ^ r2;
                    c[j+4]  = c[j];
                    c[j]    = r3;
                    c[j+8]  = r1;
                    c[j+12] = r2;
                end
            end else begin
                k = ROUNDS - 1 - r;
                for (int j = 0; j < 4; j++) begin
                    top     = c[j];
                    c[j]    = c[j+4];
                    c[j+4]  = c[j+8] ^ c[j+12] ^ c[j];
                    c[j+8]  = c[j+12] ^ c[j];
                    c[j+12] = top ^ c[j+12];
                end
                t = c;
                for (int n = 0; n < 16; n++) begin
                    c[n] = t[ROW_SHIFT_INV[n]];
                end
                for (int n = 0; n < 16; n++) begin
                    c[n] = SUB_CELL_INV[c[n] ^ tweak_mask[k][63-4*n -: 4]];
                end
            end
        end
        for (int n = 0; n < 16; n++) begin
            result[63-4*n -: 4] = c[n];
        end
        return result;
    endfunction

    task automatic send_block(input cipher_op_e op, input bit [63:0] data);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk_if.valid    <= 1'b1;
        blk_if.action   <= op;
        blk_if.block_in <= data;
        do @(posedge i_clk); while (!blk_if.ready);
        expected_blocks.push_back(skinny_transform(op, data, tk1_setting, tk2_setting));
    endtask

    task automatic wait_drained();
        blk_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_blocks.size() != 0);
    endtask

    task automatic write_register(input bit [3:0] addr, input bit [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_TWEAKEY_ONE) begin
            tk1_setting = value;
        end else if (addr == REG_TWEAKEY_TWO) begin
            tk2_setting = value;
        end
        @(posedge i_clk);
    endtask

    task automatic write_tweakeys(input bit [63:0] tk1, input bit [63:0] tk2);
        write_register(REG_TWEAKEY_ONE, tk1);
        write_register(REG_TWEAKEY_TWO, tk2);
    endtask

    // The first transaction is a decryption, so the subkey store is read on its first use.
    task automatic test_reset_tweakeys();
        send_block(OP_DECRYPT, 64'h0);
        send_block(OP_ENCRYPT, 64'h0);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, '1);
        wait_drained();
    endtask

    task automatic test_known_answer();
        write_tweakeys(64'h9eb93640d088da63, 64'h76a39d1c8bea71e1);
        send_block(OP_ENCRYPT, 64'hcf16cfe8fd0f98aa);
        send_block(OP_DECRYPT, 64'h6ceda1f43de92b9e);
        wait_drained();
    endtask

    task automatic test_extreme_tweakeys();
        bit [63:0] plain;
        write_tweakeys('1, '1);
        send_block(OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa);
        send_block(OP_DECRYPT, 64'h5555555555555555);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, 64'h0);
        wait_drained();
        write_tweakeys(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(OP_ENCRYPT, 64'h5555555555555555);
        send_block(OP_DECRYPT, 64'haaaaaaaaaaaaaaaa);
        send_block(OP_ENCRYPT, 64'h0);
        send_block(OP_DECRYPT, '1);
        plain = {$urandom, $urandom};
        send_block(OP_ENCRYPT, plain);
        send_block(OP_DECRYPT, skinny_transform(OP_ENCRYPT, plain, tk1_setting, tk2_setting));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        bit [63:0] data;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_tweakeys('1, 64'h0);
                1: write_tweakeys(64'h0, '1);
                PHASES - 1: write_tweakeys('1, '1);
                default: write_tweakeys({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            sender_gaps_on     = (p % 4 == 0) || (p % 4 == 2);
            receiver_stalls_on = (p % 4 == 0) || (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 7))
                    0: data = 64'd1 << $urandom_range(0, 63);
                    1: data = ~(64'd1 << $urandom_range(0, 63));
                    default: data = {$urandom, $urandom};
                endcase
                send_block(cipher_op_e'($urandom_range(0, 1)), data);
            end
            wait_drained();
        end
    endtask

    initial begin
        bit [63:0] want;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            int stall;
            stall = receiver_stalls_on ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            if (expected_blocks.size() == 0) begin
                $display("%0t: block_out expected none actual %016h", $time, res_if.block_out);
                mismatches++;
            end else begin
                want = expected_blocks.pop_front();
                if (res_if.block_out !== want) begin
                    $display("%0t: block_out expected %016h actual %016h",
                             $time, want, res_if.block_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        blk_if.valid    <= 1'b0;
        blk_if.action   <= OP_ENCRYPT;
        blk_if.block_in <= 64'h0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= REG_TWEAKEY_ONE;
        pwdata          <= 64'h0;
        tk1_setting        = 64'h0;
        tk2_setting        = 64'h0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_tweakeys();
        test_known_answer();
        test_extreme_tweakeys();
        test_random_traffic();
        repeat (2 * ROUNDS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_skinny64_tweakable_block_cipher: done, clean");
        end else begin
            $display("tb_skinny64_tweakable_block_cipher: done, errors");
        end
        $finish;
    end

endmodule

### skinny64_tweakable_block_cipher.f
rtl/core/skc_pkg.sv
rtl/core/skc_if.sv
rtl/core/skc_ram.sv
rtl/core/skc_ctrl.sv
rtl/core/skc_dpath.sv
rtl/core/skinny64_tweakable_block_cipher.sv
bench/tb_skinny64_tweakable_block_cipher.sv
